// ----- rtl/core/header_frame_field_extractor_unit_defines.svh -----
// Assertion helpers shared by the block.
`ifndef HEADER_FRAME_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`define HEADER_FRAME_FIELD_EXTRACTOR_UNIT_DEFINES_SVH

// checked outside reset
`define HFFE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hffe assertion failed");

// checked at every edge, reset included
`define HFFE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hffe assertion failed");

`endif

// ----- rtl/core/hffe_pkg.sv -----
`timescale 1ns / 1ps
package hffe_pkg;

  localparam int MAX_FRAME  = 10;
  localparam int CNT_W      = $clog2(MAX_FRAME + 1);
  localparam int HIST_DEPTH = 4;
  localparam int FIELD_SPAN = 5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 2'd2;

  localparam logic [7:0] FIRST_HDR_RST  = 8'h2C;
  localparam logic [7:0] SECOND_HDR_RST = 8'h12;
  localparam logic [7:0] END_MARKER_RST = 8'h5B;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HDR1 = 2'd1,
    PH_DATA = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [7:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  number;
    logic [7:0]  direction;
    logic [7:0]  found;
    logic [7:0]  task_res;
    logic        ended_by_marker;
    logic        short_frame;
    logic [15:0] frames_decoded;
  } result_t;

endpackage

// ----- rtl/core/hffe_if.sv -----
`timescale 1ns / 1ps
interface hffe_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hffe_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  number;
  logic [7:0]  direction;
  logic [7:0]  found;
  logic [7:0]  task_res;
  logic        ended_by_marker;
  logic        short_frame;
  logic [15:0] frames_decoded;

  modport source (
    output valid, output number, output direction, output found, output task_res,
    output ended_by_marker, output short_frame, output frames_decoded, input ready
  );
  modport sink (
    input valid, input number, input direction, input found, input task_res,
    input ended_by_marker, input short_frame, input frames_decoded, output ready
  );
endinterface

// ----- rtl/core/hffe_cfg_regs.sv -----
`timescale 1ns / 1ps
module hffe_cfg_regs import hffe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIRST_HDR:  cfg_d.first_header  = cfg_wdata_i;
        REG_SECOND_HDR: cfg_d.second_header = cfg_wdata_i;
        REG_END_MARKER: cfg_d.end_marker    = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_header  <= FIRST_HDR_RST;
      cfg_q.second_header <= SECOND_HDR_RST;
      cfg_q.end_marker    <= END_MARKER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/hffe_in_reg.sv -----
`timescale 1ns / 1ps
module hffe_in_reg import hffe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hffe_rx_if.sink    rx_i,
  input  logic       fire_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign rx_i.ready = !valid_q || fire_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- rtl/core/hffe_parser.sv -----
`timescale 1ns / 1ps
module hffe_parser import hffe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       hist_q [HIST_DEPTH];
  logic             shift;
  logic [7:0]       number_q, number_d;
  logic [7:0]       direction_q, direction_d;
  logic [7:0]       found_q, found_d;
  logic [7:0]       task_q, task_d;
  logic [15:0]      counter_q, counter_d;
  logic             marker;
  logic             is_short;

  assign count_inc = CNT_W'(count_q + 1'b1);
  assign marker    = (byte_i == cfg_i.end_marker);
  assign is_short  = (count_inc < CNT_W'(FIELD_SPAN));

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    shift       = 1'b0;
    number_d    = number_q;
    direction_d = direction_q;
    found_d     = found_q;
    task_d      = task_q;
    counter_d   = counter_q;
    res_valid_o = 1'b0;
    if (fire_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (byte_i == cfg_i.first_header) begin
            count_d = CNT_W'(1);
            shift   = 1'b1;
            phase_d = PH_HDR1;
          end
        end
        PH_HDR1: begin
          if (byte_i == cfg_i.second_header) begin
            count_d = count_inc;
            shift   = 1'b1;
            phase_d = PH_DATA;
          end else begin
            count_d = '0;
            phase_d = PH_IDLE;
          end
        end
        PH_DATA: begin
          count_d = count_inc;
          shift   = 1'b1;
          if (marker || count_inc == CNT_W'(MAX_FRAME)) begin
            phase_d     = PH_SKIP;
            res_valid_o = 1'b1;
            counter_d   = counter_q + 16'd1;
            if (!is_short) begin
              number_d    = hist_q[3];
              direction_d = hist_q[2];
              found_d     = hist_q[1];
              task_d      = hist_q[0];
            end
          end
        end
        PH_SKIP: begin
          count_d = '0;
          phase_d = PH_IDLE;
        end
        default: begin
          count_d = '0;
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      number_q    <= '0;
      direction_q <= '0;
      found_q     <= '0;
      task_q      <= '0;
      counter_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      number_q    <= number_d;
      direction_q <= direction_d;
      found_q     <= found_d;
      task_q      <= task_d;
      counter_q   <= counter_d;
    end
  end

  // last stored bytes, hist_q[0] newest
  always_ff @(posedge clk_i) begin
    if (shift) begin
      hist_q[0] <= byte_i;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  always_comb begin
    res_o.number          = number_d;
    res_o.direction       = direction_d;
    res_o.found           = found_d;
    res_o.task_res        = task_d;
    res_o.ended_by_marker = marker;
    res_o.short_frame     = is_short;
    res_o.frames_decoded  = counter_d;
  end

endmodule

// ----- rtl/core/hffe_out_reg.sv -----
`timescale 1ns / 1ps
module hffe_out_reg import hffe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    res_i,
  hffe_res_if.source res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid           = valid_q;
  assign res_o.number          = res_q.number;
  assign res_o.direction       = res_q.direction;
  assign res_o.found           = res_q.found;
  assign res_o.task_res        = res_q.task_res;
  assign res_o.ended_by_marker = res_q.ended_by_marker;
  assign res_o.short_frame     = res_q.short_frame;
  assign res_o.frames_decoded  = res_q.frames_decoded;

endmodule

// ----- rtl/core/header_frame_field_extractor_unit.sv -----
`timescale 1ns / 1ps
// Frame parser for a byte stream framed by two header bytes and an end marker.
// One byte beat is accepted every cycle, also while a result waits; the input
// side stalls only when both the input and result registers are full. A frame
// result beat becomes valid once the input register has taken the beat closing
// the frame and the parser state update has then loaded the result register.
// While an earlier result still waits, that update is held back. Header and
// marker values are written over the config port while idle; the user must
// keep to this, as the block itself does not enforce it.
`include "header_frame_field_extractor_unit_defines.svh"
module header_frame_field_extractor_unit import hffe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  hffe_rx_if.sink              rx_i,
  hffe_res_if.source           res_o
);

  cfg_t       cfg;
  logic       s0_valid;
  logic [7:0] s0_byte;
  logic       s0_fire;
  logic       res_valid;
  result_t    res;

  assign s0_fire = s0_valid && (!res_o.valid || res_o.ready);

  hffe_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  hffe_in_reg u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .fire_i (s0_fire),
    .valid_o(s0_valid),
    .byte_o (s0_byte)
  );

  hffe_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .fire_i     (s0_fire),
    .byte_i     (s0_byte),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  hffe_out_reg u_out (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(res_valid),
    .res_i (res),
    .res_o (res_o)
  );

  `HFFE_ASSERT(a_stall_only_when_full, clk_i, rst_ni, !rx_i.ready |-> (s0_valid && res_o.valid && !res_o.ready))
  `HFFE_ASSERT(a_result_from_beat, clk_i, rst_ni, $rose(res_o.valid) |-> $past(s0_fire))
  `HFFE_ASSERT_ALWAYS(a_reset_no_result, clk_i, !rst_ni |-> (!res_o.valid && !s0_valid))

endmodule
